@@ rtl/fkdr_pkg.sv @@
package fkdr_pkg;

  // Default structure parameters.
  localparam int TIME_BITS_DEF  = 32;
  localparam int MODE_COUNT_DEF = 3;

  // Field widths.
  localparam int NKEYS      = 4;
  localparam int NOW_BITS   = 32;
  localparam int CODE_BITS  = 7;
  localparam int MODE_BITS  = 2;
  localparam int KEY_BITS   = 2;
  localparam int DEB_BITS   = 10;
  localparam int HOLD_BITS  = 14;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 14;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_FIRST = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_INTVL = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHORD_HOLD   = 2'd3;

  // Register reset values.
  localparam logic [DEB_BITS-1:0]  DEBOUNCE_RST     = 10'd16;
  localparam logic [HOLD_BITS-1:0] REPEAT_FIRST_RST = 14'd400;
  localparam logic [HOLD_BITS-1:0] REPEAT_INTVL_RST = 14'd150;
  localparam logic [HOLD_BITS-1:0] CHORD_HOLD_RST   = 14'd400;

  // Key positions and modes.
  localparam logic [KEY_BITS-1:0]  KEY_UP    = 2'd0;
  localparam logic [KEY_BITS-1:0]  KEY_DOWN  = 2'd1;
  localparam logic [KEY_BITS-1:0]  KEY_LEFT  = 2'd2;
  localparam logic [KEY_BITS-1:0]  KEY_RIGHT = 2'd3;
  localparam logic [MODE_BITS-1:0] MODE_POSITION = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SIZE     = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BORDER   = 2'd2;

  // Timing registers as seen by the key and chord logic.
  typedef struct packed {
    logic [DEB_BITS-1:0]  debounce;
    logic [HOLD_BITS-1:0] repeat_first;
    logic [HOLD_BITS-1:0] repeat_intvl;
    logic [HOLD_BITS-1:0] chord_hold;
  } cfg_t;

  // Per-key status for the current word.
  typedef struct packed {
    logic pressed_nxt;
    logic fire;
  } key_stat_t;

  // Command character for a mode and a key; the unused mode code acts as position.
  function automatic logic [CODE_BITS-1:0] cmd_code(input logic [MODE_BITS-1:0] mode,
                                                    input logic [KEY_BITS-1:0] key);
    logic [CODE_BITS-1:0] code;
    code = 7'h2A;
    unique case ({mode, key})
      {MODE_SIZE, KEY_UP}      : code = 7'h34; // '4'
      {MODE_SIZE, KEY_DOWN}    : code = 7'h35; // '5'
      {MODE_SIZE, KEY_LEFT}    : code = 7'h68; // 'h'
      {MODE_SIZE, KEY_RIGHT}   : code = 7'h7A; // 'z'
      {MODE_BORDER, KEY_UP}    : code = 7'h43; // 'C'
      {MODE_BORDER, KEY_DOWN}  : code = 7'h44; // 'D'
      {MODE_BORDER, KEY_LEFT}  : code = 7'h42; // 'B'
      {MODE_BORDER, KEY_RIGHT} : code = 7'h41; // 'A'
      default: begin
        unique case (key)
          KEY_UP   : code = 7'h2A; // '*'
          KEY_DOWN : code = 7'h2F; // '/'
          KEY_LEFT : code = 7'h37; // '7'
          default  : code = 7'h36; // '6'
        endcase
      end
    endcase
    return code;
  endfunction

endpackage

@@ rtl/fkdr_key.sv @@
module fkdr_key #(
  parameter int TIME_BITS = fkdr_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 level_down,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 suppress,
  input  fkdr_pkg::cfg_t       cfg,
  output fkdr_pkg::key_stat_t  stat
);

  logic                 pressed_r, pressed_nxt;
  logic                 armed_r, armed_nxt;
  logic                 frd_r, frd_nxt;
  logic                 frd_deb;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] lct_r, lct_nxt;
  logic [TIME_BITS-1:0] change_el;
  logic [TIME_BITS-1:0] cmd_el;
  logic                 just;
  logic                 fire;

  assign change_el = now - start_r;

  // Debounce: a differing raw level must persist for the debounce time.
  always_comb begin
    pressed_nxt = pressed_r;
    armed_nxt   = armed_r;
    start_nxt   = start_r;
    frd_deb     = frd_r;
    just        = 1'b0;
    if (level_down != pressed_r) begin
      if (!armed_r) begin
        armed_nxt = 1'b1;
        start_nxt = now;
      end else if (change_el >= TIME_BITS'(cfg.debounce)) begin
        pressed_nxt = level_down;
        armed_nxt   = 1'b0;
        if (level_down) begin
          just    = 1'b1;
          frd_deb = 1'b0;
        end
      end
    end else begin
      armed_nxt = 1'b0;
    end
    if (!pressed_nxt) begin
      frd_deb = 1'b0;
    end
  end

  // Press command and auto-repeat timing.
  always_comb begin
    frd_nxt = frd_deb;
    lct_nxt = just ? now : lct_r;
    cmd_el  = now - lct_nxt;
    fire    = just && !suppress;
    if (pressed_nxt && !suppress) begin
      if (!frd_deb && cmd_el >= TIME_BITS'(cfg.repeat_first)) begin
        fire    = 1'b1;
        lct_nxt = now;
        frd_nxt = 1'b1;
      end else if (frd_deb && cmd_el >= TIME_BITS'(cfg.repeat_intvl)) begin
        fire    = 1'b1;
        lct_nxt = now;
      end
    end
  end

  assign stat.pressed_nxt = pressed_nxt;
  assign stat.fire        = fire;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      armed_r   <= 1'b0;
      frd_r     <= 1'b0;
    end else if (adv) begin
      pressed_r <= pressed_nxt;
      armed_r   <= armed_nxt;
      frd_r     <= frd_nxt;
    end
  end

  // Time stamps are only read once their flags say they were written.
  always_ff @(posedge clk) begin
    if (adv) begin
      start_r <= start_nxt;
      lct_r   <= lct_nxt;
    end
  end

endmodule

@@ rtl/four_key_debounce_repeat_chord_core.sv @@
// Flow: an accepted word waits in the input register; once the result register can
// take it, its result word is written there and offered on out_valid.
// Throughput: one word per cycle while out_stall is low; the input register and the
// result register let a new word enter while the previous result waits on out_stall.
// Reset (synchronous, rst_n low): keys released, timers disarmed, mode position,
// timing registers back to 16, 400, 150 and 400 ms, both registers emptied.
module four_key_debounce_repeat_chord_core #(
  parameter int TIME_BITS  = fkdr_pkg::TIME_BITS_DEF,
  parameter int MODE_COUNT = fkdr_pkg::MODE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [fkdr_pkg::NKEYS-1:0]           in_raw_key_levels,
  input  logic [fkdr_pkg::NOW_BITS-1:0]        in_now_ms,
  input  logic                                 in_serial_target_idle,
  input  logic                                 in_user_target_idle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_command_valid,
  output logic [fkdr_pkg::CODE_BITS-1:0]       out_command_code,
  output logic                                 out_command_to_user,
  output logic [fkdr_pkg::MODE_BITS-1:0]       out_control_mode,
  output logic [fkdr_pkg::NKEYS-1:0]           out_debounced_keys,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fkdr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fkdr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int MODE_LAST_I = MODE_COUNT - 1;
  localparam logic [fkdr_pkg::MODE_BITS-1:0] MODE_LAST =
    MODE_LAST_I[fkdr_pkg::MODE_BITS-1:0];

  fkdr_pkg::cfg_t                      cfg_r;
  logic                                in_vld_r;
  logic [fkdr_pkg::NKEYS-1:0]          in_levels_r;
  logic [TIME_BITS-1:0]                in_now_r;
  logic                                in_sidle_r;
  logic                                in_uidle_r;
  logic                                adv;
  logic                                in_acc;
  fkdr_pkg::key_stat_t [fkdr_pkg::NKEYS-1:0] stat;
  logic [fkdr_pkg::NKEYS-1:0]          pressed_nxt;
  logic [fkdr_pkg::NKEYS-1:0]          fire;
  logic                                chord;
  logic                                chord_armed_r, chord_armed_nxt;
  logic                                chord_fired_r, chord_fired_nxt;
  logic [TIME_BITS-1:0]                chord_start_r, chord_start_nxt;
  logic [TIME_BITS-1:0]                chord_el;
  logic [fkdr_pkg::MODE_BITS-1:0]      mode_r, mode_nxt;
  logic                                to_user;
  logic                                target_idle;
  logic                                cmd_vld;
  logic [fkdr_pkg::KEY_BITS-1:0]       cmd_key;
  logic                                out_vld_r;
  logic                                out_cmd_vld_r;
  logic [fkdr_pkg::CODE_BITS-1:0]      out_code_r;
  logic                                out_user_r;
  logic [fkdr_pkg::MODE_BITS-1:0]      out_mode_r;
  logic [fkdr_pkg::NKEYS-1:0]          out_keys_r;

  // Handshake: the work stage advances when the result register can take a word.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Timing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce     <= fkdr_pkg::DEBOUNCE_RST;
      cfg_r.repeat_first <= fkdr_pkg::REPEAT_FIRST_RST;
      cfg_r.repeat_intvl <= fkdr_pkg::REPEAT_INTVL_RST;
      cfg_r.chord_hold   <= fkdr_pkg::CHORD_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fkdr_pkg::CFG_DEBOUNCE     : cfg_r.debounce <= cfg_data[fkdr_pkg::DEB_BITS-1:0];
        fkdr_pkg::CFG_REPEAT_FIRST : cfg_r.repeat_first <= cfg_data;
        fkdr_pkg::CFG_REPEAT_INTVL : cfg_r.repeat_intvl <= cfg_data;
        fkdr_pkg::CFG_CHORD_HOLD   : cfg_r.chord_hold <= cfg_data;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_levels_r <= in_raw_key_levels;
      in_now_r    <= TIME_BITS'(in_now_ms);
      in_sidle_r  <= in_serial_target_idle;
      in_uidle_r  <= in_user_target_idle;
    end
  end

  // One debounce and repeat unit per key; LEFT and RIGHT are muted while chorded.
  for (genvar k = 0; k < fkdr_pkg::NKEYS; k++) begin : g_key
    logic suppress;
    assign suppress = chord &&
      ((k == int'(fkdr_pkg::KEY_LEFT)) || (k == int'(fkdr_pkg::KEY_RIGHT)));
    fkdr_key #(
      .TIME_BITS(TIME_BITS)
    ) u_key (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .level_down (!in_levels_r[k]),
      .now        (in_now_r),
      .suppress   (suppress),
      .cfg        (cfg_r),
      .stat       (stat[k])
    );
    assign pressed_nxt[k] = stat[k].pressed_nxt;
    assign fire[k]        = stat[k].fire;
  end

  // Chord timer and mode stepping.
  assign chord    = pressed_nxt[fkdr_pkg::KEY_LEFT] && pressed_nxt[fkdr_pkg::KEY_RIGHT];
  assign chord_el = in_now_r - chord_start_r;

  always_comb begin
    chord_armed_nxt = chord_armed_r;
    chord_fired_nxt = chord_fired_r;
    chord_start_nxt = chord_start_r;
    mode_nxt        = mode_r;
    if (chord) begin
      if (!chord_armed_r) begin
        chord_armed_nxt = 1'b1;
        chord_start_nxt = in_now_r;
        chord_fired_nxt = 1'b0;
      end else if (!chord_fired_r && chord_el >= TIME_BITS'(cfg_r.chord_hold)) begin
        mode_nxt        = (mode_r >= MODE_LAST) ? fkdr_pkg::MODE_POSITION
                                                : mode_r + 1'b1;
        chord_fired_nxt = 1'b1;
      end
    end else begin
      chord_armed_nxt = 1'b0;
      chord_fired_nxt = 1'b0;
    end
  end

  // Target selection and first firing key in UP, DOWN, LEFT, RIGHT order.
  assign to_user     = (mode_nxt == fkdr_pkg::MODE_BORDER);
  assign target_idle = to_user ? in_uidle_r : in_sidle_r;
  assign cmd_vld     = (|fire) && target_idle;

  always_comb begin
    priority if (fire[fkdr_pkg::KEY_UP]) begin
      cmd_key = fkdr_pkg::KEY_UP;
    end else if (fire[fkdr_pkg::KEY_DOWN]) begin
      cmd_key = fkdr_pkg::KEY_DOWN;
    end else if (fire[fkdr_pkg::KEY_LEFT]) begin
      cmd_key = fkdr_pkg::KEY_LEFT;
    end else begin
      cmd_key = fkdr_pkg::KEY_RIGHT;
    end
  end

  // Chord and mode control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chord_armed_r <= 1'b0;
      chord_fired_r <= 1'b0;
      mode_r        <= fkdr_pkg::MODE_POSITION;
    end else if (adv) begin
      chord_armed_r <= chord_armed_nxt;
      chord_fired_r <= chord_fired_nxt;
      mode_r        <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chord_start_r <= chord_start_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cmd_vld_r <= cmd_vld;
      out_code_r    <= cmd_vld ? fkdr_pkg::cmd_code(mode_nxt, cmd_key) : '0;
      out_user_r    <= cmd_vld && to_user;
      out_mode_r    <= mode_nxt;
      out_keys_r    <= pressed_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_command_valid   = out_cmd_vld_r;
  assign out_command_code    = out_code_r;
  assign out_command_to_user = out_user_r;
  assign out_control_mode    = out_mode_r;
  assign out_debounced_keys  = out_keys_r;

endmodule

@@ rtl/fkdr_checker.sv @@
module fkdr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_command_valid,
  input logic [fkdr_pkg::CODE_BITS-1:0] out_command_code,
  input logic                           out_command_to_user,
  input logic [fkdr_pkg::MODE_BITS-1:0] out_control_mode
);

  // A result word held back by the consumer stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // Without a command the code and target read as zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_command_valid |-> out_command_code == '0 && !out_command_to_user)
    else $error("idle result carries a command");

  // The mode never takes the unused code.
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_control_mode != 2'd3)
    else $error("control mode out of range");

  // Commands go to the user target exactly in border mode.
  a_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_valid |->
      out_command_to_user == (out_control_mode == fkdr_pkg::MODE_BORDER))
    else $error("command target does not match mode");

endmodule

bind four_key_debounce_repeat_chord_core fkdr_checker u_fkdr_checker (.*);
